// ----- src/max_pooling_2d_macros.svh -----
// Assertion helpers for the max pooling block
`ifndef MAX_POOLING_2D_MACROS_SVH
`define MAX_POOLING_2D_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define MP2D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define MP2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mp2d_pkg.sv -----
`timescale 1ns / 1ps

package mp2d_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_KERNEL_DEF = 8;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // Fixed plane geometry
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ROW_W      = 12;  // output row / row position
  localparam int unsigned SIZE_W     = 13;  // plane sizes and position compares

  // Register widths
  localparam int unsigned KREG_W     = 4;
  localparam int unsigned HREG_W     = 13;
  localparam int unsigned WREG_W     = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_R = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_H  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_W  = 3'd5;

  // Position/stride division: one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = 4;

  typedef enum logic {
    ST_DIV,
    ST_RUN
  } state_e;

endpackage

// ----- src/mp2d_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, read-first, registered read
module mp2d_ram #(
  parameter int unsigned WIDTH = mp2d_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = mp2d_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/max_pooling_2d.sv -----
`timescale 1ns / 1ps
// Streaming 2-D max pooling over a padded plane, one pixel per request.
// Slave stream: one pixel per request in raster order, padding sent as the
//   most negative sample. Master stream: one window maximum with its output
//   row and column; tlast marks the last window of the plane.
// Configuration: write kernel, stride and plane size through cfg_we_i /
//   cfg_index_i / cfg_data_i while the stream is idle.
// Throughput: one pixel per cycle while the receiver takes results, set by the line
//   store (one RAM per kept row, all read per pixel at its column, one written).
// The pixel that closes a window is registered with the RAM reads, then
//   compared, and the maximum is held in the output register.
// After reset and after every configuration write, s_axis_tready stays low
//   while the window origin of the current position is divided by the
//   strides, one quotient bit per cycle.
// Reset returns to the first pixel of a plane with 2x2 kernel, stride 2 and
//   a 1024x1024 plane; the line store is not cleared.
// When the receiver stalls, the waiting result is held and pixels go on into
//   the compare stage until one closes a window; that one waits for the result to leave.
`include "max_pooling_2d_macros.svh"

module max_pooling_2d #(
  parameter int unsigned MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_KERNEL  = mp2d_pkg::MAX_KERNEL_DEF,
  parameter int unsigned DATA_WIDTH  = mp2d_pkg::DATA_WIDTH_DEF,
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH),
  localparam int unsigned IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W =
    ((DATA_WIDTH + mp2d_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata,  // pixel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_TDATA_W-1:0]          m_axis_tdata,  // max_value, out_row, out_col
  output logic                            m_axis_tlast
);

  localparam int unsigned LINE_ROWS = MAX_KERNEL - 1;
  localparam int unsigned SLOT_W    = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int unsigned CMOD_W    = $clog2(MAX_KERNEL);
  localparam int unsigned KW_W      = $clog2(MAX_KERNEL + 1);
  localparam int unsigned ROW_W     = mp2d_pkg::ROW_W;
  localparam int unsigned SIZE_W    = mp2d_pkg::SIZE_W;
  localparam int unsigned KREG_W    = mp2d_pkg::KREG_W;
  localparam int unsigned DCNT_W    = mp2d_pkg::DIV_CNT_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [KREG_W-1:0]           cfg_kh_q, cfg_kw_q, cfg_sr_q, cfg_sc_q;
  logic [mp2d_pkg::HREG_W-1:0] cfg_ph_q;
  logic [mp2d_pkg::WREG_W-1:0] cfg_pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_kh_q <= KREG_W'(2);
      cfg_kw_q <= KREG_W'(2);
      cfg_sr_q <= KREG_W'(2);
      cfg_sc_q <= KREG_W'(2);
      cfg_ph_q <= mp2d_pkg::HREG_W'(1024);
      cfg_pw_q <= mp2d_pkg::WREG_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mp2d_pkg::CFG_KERNEL_H: cfg_kh_q <= cfg_data_i[KREG_W-1:0];
        mp2d_pkg::CFG_KERNEL_W: cfg_kw_q <= cfg_data_i[KREG_W-1:0];
        mp2d_pkg::CFG_STRIDE_R: cfg_sr_q <= cfg_data_i[KREG_W-1:0];
        mp2d_pkg::CFG_STRIDE_C: cfg_sc_q <= cfg_data_i[KREG_W-1:0];
        mp2d_pkg::CFG_PLANE_H:  cfg_ph_q <= cfg_data_i[mp2d_pkg::HREG_W-1:0];
        mp2d_pkg::CFG_PLANE_W:  cfg_pw_q <= cfg_data_i[mp2d_pkg::WREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective values: zero means one, oversize saturates
  logic [KW_W-1:0]   kh, kw;
  logic [KREG_W-1:0] sr, sc;
  logic [SIZE_W-1:0] h, w;

  always_comb begin
    kh = (cfg_kh_q == '0) ? KW_W'(1) :
         ((32'(cfg_kh_q) > MAX_KERNEL) ? KW_W'(MAX_KERNEL) : KW_W'(cfg_kh_q));
    kw = (cfg_kw_q == '0) ? KW_W'(1) :
         ((32'(cfg_kw_q) > MAX_KERNEL) ? KW_W'(MAX_KERNEL) : KW_W'(cfg_kw_q));
    sr = (cfg_sr_q == '0) ? KREG_W'(1) : cfg_sr_q;
    sc = (cfg_sc_q == '0) ? KREG_W'(1) : cfg_sc_q;
    h  = (cfg_ph_q == '0) ? SIZE_W'(1) :
         ((32'(cfg_ph_q) > mp2d_pkg::MAX_HEIGHT) ? SIZE_W'(mp2d_pkg::MAX_HEIGHT)
                                                  : SIZE_W'(cfg_ph_q));
    w  = (cfg_pw_q == '0) ? SIZE_W'(1) :
         ((32'(cfg_pw_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : SIZE_W'(cfg_pw_q));
  end

  // ---------------------------------------------------------------------
  // Control FSM: divide phase after reset / config write, then streaming
  mp2d_pkg::state_e state_q, state_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic div_busy, run;

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = mp2d_pkg::ST_DIV;
    end else begin
      unique case (state_q)
        mp2d_pkg::ST_DIV: begin
          if (cnt_q == DCNT_W'(ROW_W - 1)) state_d = mp2d_pkg::ST_RUN;
        end
        mp2d_pkg::ST_RUN: ;
        default: state_d = mp2d_pkg::ST_DIV;
      endcase
    end
  end

  always_comb begin
    div_busy = 1'b0;
    run      = 1'b0;
    unique case (state_q)
      mp2d_pkg::ST_DIV: div_busy = 1'b1;
      mp2d_pkg::ST_RUN: run      = 1'b1;
      default:          div_busy = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Positions and window phase counters
  // rr/rq: (row+1-kh) mod / div stride_rows, cc/cq likewise for columns
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;      // row mod LINE_ROWS
  logic [CMOD_W-1:0] cmod_q, cmod_d;      // col mod MAX_KERNEL
  logic [KREG_W-1:0] rr_q, rr_d, cc_q, cc_d;
  logic [ROW_W-1:0]  rq_q, rq_d, cq_q, cq_d;

  logic accept;
  logic s1_adv;
  logic s1_valid_q;

  logic [SIZE_W-1:0] row_ext, col_ext;
  logic in_plane, row_full, col_full, col_wrap, row_wrap;
  logic [ROW_W-1:0]  row_nx;
  logic [COL_W-1:0]  col_nx;
  logic [ROW_W-1:0]  rdiv, cdiv;
  logic [DCNT_W-1:0] div_idx;
  logic [KREG_W:0]   row_t, col_t;
  logic s0_win, s0_last;

  assign s_axis_tready = run && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    row_ext  = SIZE_W'(row_q);
    col_ext  = SIZE_W'(col_q);
    in_plane = (row_ext < h) && (col_ext < w);
    row_full = (row_ext + SIZE_W'(1)) >= SIZE_W'(kh);
    col_full = (col_ext + SIZE_W'(1)) >= SIZE_W'(kw);
    col_wrap = (col_ext + SIZE_W'(1)) >= w;
    row_wrap = (row_ext + SIZE_W'(1)) >= h;
    row_nx   = row_wrap ? '0 : row_q + ROW_W'(1);
    col_nx   = col_wrap ? '0 : col_q + COL_W'(1);
    s0_win   = in_plane && row_full && col_full && (rr_q == '0) && (cc_q == '0);
    // last window: no further stride step fits in either direction
    s0_last  = ((row_ext + SIZE_W'(sr)) >= h) && ((col_ext + SIZE_W'(sc)) >= w);
    // divider operands: window origin row / column
    rdiv     = ROW_W'(row_ext + SIZE_W'(1) - SIZE_W'(kh));
    cdiv     = ROW_W'(col_ext + SIZE_W'(1) - SIZE_W'(kw));
    div_idx  = DCNT_W'(ROW_W - 1) - cnt_q;
    row_t    = {rr_q, rdiv[div_idx]};
    col_t    = {cc_q, cdiv[div_idx]};
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    cmod_d = cmod_q;
    rr_d   = rr_q;
    rq_d   = rq_q;
    cc_d   = cc_q;
    cq_d   = cq_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      rr_d  = '0;
      rq_d  = '0;
      cc_d  = '0;
      cq_d  = '0;
      cnt_d = '0;
    end else if (div_busy) begin
      // restoring division, one quotient bit per cycle
      cnt_d = cnt_q + DCNT_W'(1);
      if (row_t >= {1'b0, sr}) begin
        rr_d = KREG_W'(row_t - {1'b0, sr});
        rq_d = {rq_q[ROW_W-2:0], 1'b1};
      end else begin
        rr_d = row_t[KREG_W-1:0];
        rq_d = {rq_q[ROW_W-2:0], 1'b0};
      end
      if (col_t >= {1'b0, sc}) begin
        cc_d = KREG_W'(col_t - {1'b0, sc});
        cq_d = {cq_q[ROW_W-2:0], 1'b1};
      end else begin
        cc_d = col_t[KREG_W-1:0];
        cq_d = {cq_q[ROW_W-2:0], 1'b0};
      end
    end else if (accept) begin
      col_d  = col_nx;
      cmod_d = (col_wrap || cmod_q == CMOD_W'(MAX_KERNEL - 1)) ? '0
                                                                : cmod_q + CMOD_W'(1);
      if ((SIZE_W'(col_nx) + SIZE_W'(1)) == SIZE_W'(kw)) begin
        cc_d = '0;
        cq_d = '0;
      end else if (cc_q == sc - KREG_W'(1)) begin
        cc_d = '0;
        cq_d = cq_q + ROW_W'(1);
      end else begin
        cc_d = cc_q + KREG_W'(1);
      end
      if (col_wrap) begin
        row_d  = row_nx;
        slot_d = (row_wrap || slot_q == SLOT_W'(LINE_ROWS - 1)) ? '0
                                                                  : slot_q + SLOT_W'(1);
        if ((SIZE_W'(row_nx) + SIZE_W'(1)) == SIZE_W'(kh)) begin
          rr_d = '0;
          rq_d = '0;
        end else if (rr_q == sr - KREG_W'(1)) begin
          rr_d = '0;
          rq_d = rq_q + ROW_W'(1);
        end else begin
          rr_d = rr_q + KREG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mp2d_pkg::ST_DIV;
      cnt_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= '0;
      cmod_q  <= '0;
      rr_q    <= '0;
      rq_q    <= '0;
      cc_q    <= '0;
      cq_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
      slot_q  <= slot_d;
      cmod_q  <= cmod_d;
      rr_q    <= rr_d;
      rq_q    <= rq_d;
      cc_q    <= cc_d;
      cq_q    <= cq_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: one RAM per kept row, all read at the pixel's column,
  // the pixel written into the slot of its own row
  logic signed [DATA_WIDTH-1:0] pixel;
  logic signed [DATA_WIDTH-1:0] row_rd [LINE_ROWS];

  assign pixel = s_axis_tdata[DATA_WIDTH-1:0];

  for (genvar gi = 0; gi < LINE_ROWS; gi++) begin : g_line
    logic row_we;
    assign row_we = accept && in_plane && (slot_q == SLOT_W'(gi));
    mp2d_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_WIDTH)
    ) u_row_ram (
      .clk_i   (clk_i),
      .we_i    (row_we),
      .waddr_i (col_q),
      .wdata_i (pixel),
      .re_i    (accept),
      .raddr_i (col_q),
      .rdata_o (row_rd[gi])
    );
  end

  // ---------------------------------------------------------------------
  // Compare stage
  logic signed [DATA_WIDTH-1:0] s1_px_q;
  logic [SLOT_W-1:0]            s1_slot_q;
  logic [CMOD_W-1:0]            s1_cmod_q;
  logic [KW_W-1:0]              s1_kh_q, s1_kw_q;
  logic                         s1_col_q, s1_win_q, s1_last_q;
  logic [ROW_W-1:0]             s1_orow_q;
  logic [COL_W-1:0]             s1_ocol_q;
  logic                         m_valid_q;

  assign s1_adv = s1_valid_q && (!s1_win_q || !m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel;
      s1_slot_q <= slot_q;
      s1_cmod_q <= cmod_q;
      s1_kh_q   <= kh;
      s1_kw_q   <= kw;
      s1_col_q  <= in_plane && row_full;
      s1_win_q  <= s0_win;
      s1_last_q <= s0_last;
      s1_orow_q <= rq_q;
      s1_ocol_q <= cq_q[COL_W-1:0];
    end
  end

  // Rows of the window above the current one: slot distance below kh
  logic [KW_W-1:0] row_dist [LINE_ROWS];
  logic            row_use  [LINE_ROWS];

  always_comb begin
    for (int i = 0; i < LINE_ROWS; i++) begin
      if (s1_slot_q >= SLOT_W'(i)) begin
        row_dist[i] = KW_W'(s1_slot_q) - KW_W'(i);
      end else begin
        row_dist[i] = KW_W'(s1_slot_q) + KW_W'(LINE_ROWS) - KW_W'(i);
      end
      if (row_dist[i] == '0) row_dist[i] = KW_W'(LINE_ROWS);
      row_use[i] = row_dist[i] < s1_kh_q;
    end
  end

  // Column maximum over the kernel rows
  logic signed [DATA_WIDTH-1:0] col_max;

  always_comb begin
    col_max = s1_px_q;
    for (int i = 0; i < LINE_ROWS; i++) begin
      if (row_use[i] && row_rd[i] > col_max) col_max = row_rd[i];
    end
  end

  // Ring of column maxima, indexed by column mod MAX_KERNEL
  logic signed [DATA_WIDTH-1:0] ring_q [MAX_KERNEL];
  logic [KW_W-1:0]              ring_dist [MAX_KERNEL];
  logic                         ring_use  [MAX_KERNEL];
  logic signed [DATA_WIDTH-1:0] ring_best;
  logic                         ring_any;
  logic signed [DATA_WIDTH-1:0] win_max;

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_col_q) begin
      ring_q[s1_cmod_q] <= col_max;
    end
  end

  // Earlier columns of the window: ring distance 1 .. kw-1
  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      if (s1_cmod_q >= CMOD_W'(j)) begin
        ring_dist[j] = KW_W'(s1_cmod_q) - KW_W'(j);
      end else begin
        ring_dist[j] = KW_W'(s1_cmod_q) + KW_W'(MAX_KERNEL) - KW_W'(j);
      end
      ring_use[j] = (ring_dist[j] != '0) && (ring_dist[j] < s1_kw_q);
    end
  end

  always_comb begin
    ring_best = '0;
    ring_any  = 1'b0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      if (ring_use[j] && (!ring_any || ring_q[j] > ring_best)) begin
        ring_best = ring_q[j];
        ring_any  = 1'b1;
      end
    end
    win_max = (ring_any && ring_best > col_max) ? ring_best : col_max;
  end

  // ---------------------------------------------------------------------
  // Output register
  logic signed [DATA_WIDTH-1:0] m_max_q;
  logic [ROW_W-1:0]             m_row_q;
  logic [COL_W-1:0]             m_col_q;
  logic                         m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv && s1_win_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_win_q) begin
      m_max_q  <= win_max;
      m_row_q  <= s1_orow_q;
      m_col_q  <= s1_ocol_q;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_col_q, m_row_q, m_max_q});
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  `MP2D_ASSERT_SAME(a_out_from_s1, clk_i, rst_ni, $rose(m_valid_q), $past(s1_valid_q && s1_win_q), "result without a window in the compare stage")
  `MP2D_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_px_q), "stalled compare stage lost its pixel")
  `MP2D_ASSERT_SAME(a_phase_range, clk_i, rst_ni, state_q == mp2d_pkg::ST_RUN, (rr_q < sr) && (cc_q < sc), "window phase not below stride")

endmodule
